// ===== rtl/voltage_foc_position_drive_assert.svh =====
// Assertion macros for the drive's RTL.
// Each macro takes a label, an antecedent and a consequent, sampled on clk_i
// and switched off while rst_ni is low.
`ifndef VOLTAGE_FOC_POSITION_DRIVE_ASSERT_SVH
`define VOLTAGE_FOC_POSITION_DRIVE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VFPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VFPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/vfpd_pkg.sv =====
package vfpd_pkg;

  // Fixed-point limits in Q8.8 volts; the sqrt(3)/2 constant is Q1.15.
  localparam int UQ_LIMIT       = 1280;
  localparam int PHASE_MAX      = 2560;
  localparam int SQRT3_HALF_Q15 = 28378;

  // Sine polynomial coefficients.
  localparam int unsigned SIN_A = 51472;
  localparam int unsigned SIN_B = 21024;
  localparam int unsigned SIN_C = 2320;

  // Register port geometry.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Register reset values.
  localparam logic [11:0] RST_ANGLE_OFFSET  = 12'd0;
  localparam logic [12:0] RST_TARGET        = 13'd0;
  localparam logic [15:0] RST_GAIN          = 16'd256;
  localparam logic [11:0] RST_SUPPLY        = 12'd2560;
  localparam logic [11:0] RST_FULL_SCALE    = 12'd2560;
  localparam logic [6:0]  RST_POLE_PAIRS    = 7'd7;
  localparam logic        RST_ALIGN_MODE    = 1'b0;
  localparam logic [10:0] RST_ALIGN_VOLTAGE = 11'd768;

  // Register indexes.
  typedef enum logic [2:0] {
    REG_ANGLE_OFFSET  = 3'd0,
    REG_TARGET        = 3'd1,
    REG_GAIN          = 3'd2,
    REG_SUPPLY        = 3'd3,
    REG_FULL_SCALE    = 3'd4,
    REG_POLE_PAIRS    = 3'd5,
    REG_ALIGN_MODE    = 3'd6,
    REG_ALIGN_VOLTAGE = 3'd7
  } reg_idx_e;

  // Q1.15 sine of table entry k in a table of 2^abits entries.
  function automatic logic signed [15:0] sine_q15(input int unsigned k,
                                                  input int unsigned abits);
    int unsigned n;
    int unsigned qlen;
    int unsigned kk;
    int unsigned quad;
    int unsigned pos;
    int unsigned z;
    int unsigned z2;
    int unsigned inner;
    int unsigned mid;
    int unsigned r;
    n     = 32'd1 << abits;
    qlen  = n >> 2;
    kk    = k & (n - 1);
    quad  = (kk >> (abits - 2)) & 32'd3;
    pos   = kk & (qlen - 1);
    if (quad[0]) begin
      pos = qlen - pos;
    end
    z     = pos << (17 - abits);
    z2    = (z * z) >> 15;
    inner = SIN_B - ((SIN_C * z2) >> 15);
    mid   = SIN_A - ((z2 * inner) >> 15);
    r     = (z * mid) >> 15;
    if (r > 32'd32767) begin
      r = 32'd32767;
    end
    if (quad[1]) begin
      return 16'(32'd0 - r);
    end
    return 16'(r);
  endfunction

endpackage

// ===== rtl/voltage_foc_position_drive.sv =====
// Voltage-mode position drive: one encoder angle in, three PWM compare values
// and the quadrature voltage command out.
// Input channel: sensor_angle_i with in_valid_i / in_stall_o. Output channel:
// duty_a_o, duty_b_o, duty_c_o, q_voltage_o with out_valid_o / out_stall_i.
// A request is taken at a clock edge where valid is high and stall is low.
// The datapath is a pipeline of 6 + clog2(PWM_PERIOD+1) register stages:
// angle reduction, gain and sine ROM read, inverse Park, inverse Clarke
// scaling, phase clamp, duty product, then a restoring divider by
// full_scale_voltage that resolves one quotient bit per stage. A new request
// enters every cycle unless the pipeline stalls; the rate is one per clock.
// While the receiver stalls a waiting result, the whole pipeline holds and
// in_stall_o is raised; nothing is lost or repeated. Bubbles hold with it.
// Reset empties the pipeline and loads the register defaults; the block
// takes requests from the first cycle after reset. Configuration goes
// through an APB-style port, register i at byte address 4*i, and the user
// changes it only while the pipeline is empty; the block does not enforce it.
`include "voltage_foc_position_drive_assert.svh"

module voltage_foc_position_drive #(
  parameter int PWM_PERIOD     = 5250,
  parameter int SINE_ADDR_BITS = 10,
  parameter int TURN_BITS      = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [vfpd_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [vfpd_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [vfpd_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [23:0]                    sensor_angle_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [12:0]                           duty_a_o,
  output logic [12:0]                           duty_b_o,
  output logic [12:0]                           duty_c_o,
  output logic signed [11:0]                    q_voltage_o
);

  localparam int TB    = TURN_BITS;
  localparam int AB    = SINE_ADDR_BITS;
  localparam int NLUT  = 2 ** AB;
  localparam int SH    = TB - AB;
  localparam int EW    = ((TB + 1 > 13) ? TB + 1 : 13) + 1;
  localparam int GW    = EW + 17;
  localparam int PW    = $clog2(PWM_PERIOD + 1);
  localparam int NW    = 12 + PW;
  localparam int LW    = NW + 1;
  localparam int NST   = 6 + PW;
  localparam logic [AB-1:0] QUARTER = AB'(2 ** (AB - 2));
  localparam logic [PW-1:0] PERIOD  = PW'(PWM_PERIOD);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [11:0]        angle_offset_q;
  logic signed [12:0] target_position_q;
  logic [15:0]        position_gain_q;
  logic [11:0]        supply_offset_q;
  logic [11:0]        full_scale_q;
  logic [6:0]         pole_pairs_q;
  logic               align_mode_q;
  logic [10:0]        align_voltage_q;
  logic [LW-1:0]      fs_limit_q;
  logic               cfg_wr;
  vfpd_pkg::reg_idx_e cfg_idx;

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = vfpd_pkg::reg_idx_e'(paddr[4:2]);
  assign pready  = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_offset_q    <= vfpd_pkg::RST_ANGLE_OFFSET;
      target_position_q <= vfpd_pkg::RST_TARGET;
      position_gain_q   <= vfpd_pkg::RST_GAIN;
      supply_offset_q   <= vfpd_pkg::RST_SUPPLY;
      full_scale_q      <= vfpd_pkg::RST_FULL_SCALE;
      pole_pairs_q      <= vfpd_pkg::RST_POLE_PAIRS;
      align_mode_q      <= vfpd_pkg::RST_ALIGN_MODE;
      align_voltage_q   <= vfpd_pkg::RST_ALIGN_VOLTAGE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        vfpd_pkg::REG_ANGLE_OFFSET:  angle_offset_q    <= pwdata[11:0];
        vfpd_pkg::REG_TARGET:        target_position_q <= pwdata[12:0];
        vfpd_pkg::REG_GAIN:          position_gain_q   <= pwdata[15:0];
        vfpd_pkg::REG_SUPPLY:        supply_offset_q   <= pwdata[11:0];
        vfpd_pkg::REG_FULL_SCALE:    full_scale_q      <= pwdata[11:0];
        vfpd_pkg::REG_POLE_PAIRS:    pole_pairs_q      <= pwdata[6:0];
        vfpd_pkg::REG_ALIGN_MODE:    align_mode_q      <= pwdata[0];
        vfpd_pkg::REG_ALIGN_VOLTAGE: align_voltage_q   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Duty saturation threshold: the product at which the quotient passes the period.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_limit_q <= LW'(vfpd_pkg::RST_FULL_SCALE) * LW'(PWM_PERIOD + 1);
    end else begin
      fs_limit_q <= LW'(full_scale_q) * LW'(PWM_PERIOD + 1);
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_idx)
      vfpd_pkg::REG_ANGLE_OFFSET:  prdata = 32'(angle_offset_q);
      vfpd_pkg::REG_TARGET:        prdata = 32'(target_position_q);
      vfpd_pkg::REG_GAIN:          prdata = 32'(position_gain_q);
      vfpd_pkg::REG_SUPPLY:        prdata = 32'(supply_offset_q);
      vfpd_pkg::REG_FULL_SCALE:    prdata = 32'(full_scale_q);
      vfpd_pkg::REG_POLE_PAIRS:    prdata = 32'(pole_pairs_q);
      vfpd_pkg::REG_ALIGN_MODE:    prdata = 32'(align_mode_q);
      vfpd_pkg::REG_ALIGN_VOLTAGE: prdata = 32'(align_voltage_q);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------
  logic [NST-1:0] valid_q;
  logic           advance;
  logic           in_accept;

  assign advance    = !(valid_q[NST-1] && out_stall_i);
  assign in_stall_o = !advance;
  assign in_accept  = in_valid_i && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[NST-2:0], in_accept};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: angle reduction, position error, electrical angle
  // ---------------------------------------------------------------------
  logic signed [24:0]   diff;
  logic [TB-1:0]        diff_low;
  logic signed [TB:0]   norm;
  logic [TB+6:0]        eprod;
  logic signed [EW-1:0] err_d, err_q;
  logic [TB-1:0]        ephase_d, ephase_q;
  logic                 align_q;

  assign diff     = $signed({sensor_angle_i[23], sensor_angle_i})
                  - $signed({13'd0, angle_offset_q});
  assign diff_low = diff[TB-1:0];
  // Truncated remainder: a negative difference keeps a negative remainder.
  assign norm     = (diff[24] && (diff_low != '0))
                  ? $signed({1'b0, diff_low}) + $signed({1'b1, {TB{1'b0}}})
                  : $signed({1'b0, diff_low});
  assign err_d    = EW'(target_position_q) - EW'(norm);
  assign eprod    = (TB+7)'(diff_low) * (TB+7)'(pole_pairs_q);
  assign ephase_d = align_mode_q ? '0 : eprod[TB-1:0];

  always_ff @(posedge clk_i) begin
    if (advance) begin
      err_q    <= err_d;
      ephase_q <= ephase_d;
      align_q  <= align_mode_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: proportional gain with saturation or align voltage, sine and cosine ROM read
  // ---------------------------------------------------------------------
  logic signed [GW-1:0] gprod;
  logic signed [GW-1:0] gdiv;
  logic signed [11:0]   uq_d;
  logic signed [11:0]   uq2_q;
  logic [AB-1:0]        sin_addr;
  logic [AB-1:0]        cos_addr;
  logic signed [15:0]   sine_rom [NLUT];
  logic signed [15:0]   sin_q, cos_q;

  for (genvar k = 0; k < NLUT; k++) begin : g_rom
    assign sine_rom[k] = vfpd_pkg::sine_q15(k, AB);
  end

  if (SH >= 0) begin : g_addr_shr
    assign sin_addr = ephase_q[TB-1:SH];
  end else begin : g_addr_shl
    assign sin_addr = {ephase_q, {(-SH){1'b0}}};
  end
  assign cos_addr = sin_addr + QUARTER;

  assign gprod = $signed({1'b0, position_gain_q}) * err_q;
  assign gdiv  = GW'((gprod + ((gprod < 0) ? 255 : 0)) >>> 8);

  always_comb begin
    if (align_q) begin
      uq_d = (align_voltage_q > vfpd_pkg::UQ_LIMIT) ? 12'(vfpd_pkg::UQ_LIMIT)
                                                     : 12'(align_voltage_q);
    end else if (gdiv > vfpd_pkg::UQ_LIMIT) begin
      uq_d = 12'(vfpd_pkg::UQ_LIMIT);
    end else if (gdiv < -vfpd_pkg::UQ_LIMIT) begin
      uq_d = 12'(-vfpd_pkg::UQ_LIMIT);
    end else begin
      uq_d = 12'(gdiv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      uq2_q <= uq_d;
      sin_q <= sine_rom[sin_addr];
      cos_q <= sine_rom[cos_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: inverse Park with ud at zero
  // ---------------------------------------------------------------------
  logic signed [27:0] ps, pc;
  logic signed [27:0] ts, tc;
  logic signed [11:0] ualpha_d, ubeta_d;
  logic signed [11:0] ualpha3_q, ubeta3_q, uq3_q;

  assign ps       = uq2_q * sin_q;
  assign pc       = uq2_q * cos_q;
  assign ts       = 28'((ps + ((ps < 0) ? 32767 : 0)) >>> 15);
  assign tc       = 28'((pc + ((pc < 0) ? 32767 : 0)) >>> 15);
  assign ualpha_d = 12'(-ts);
  assign ubeta_d  = 12'(tc);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ualpha3_q <= ualpha_d;
      ubeta3_q  <= ubeta_d;
      uq3_q     <= uq2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: inverse Clarke terms
  // ---------------------------------------------------------------------
  logic signed [27:0] sp;
  logic signed [11:0] halfa_d, sb_d;
  logic signed [11:0] ualpha4_q, halfa4_q, sb4_q, uq4_q;

  assign halfa_d = 12'((ualpha3_q + ((ualpha3_q < 0) ? 1 : 0)) >>> 1);
  assign sp      = ubeta3_q * $signed(16'(vfpd_pkg::SQRT3_HALF_Q15));
  assign sb_d    = 12'((sp + ((sp < 0) ? 32767 : 0)) >>> 15);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ualpha4_q <= ualpha3_q;
      halfa4_q  <= halfa_d;
      sb4_q     <= sb_d;
      uq4_q     <= uq3_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: phase voltages with half supply, clamped to 0..10 V
  // ---------------------------------------------------------------------
  function automatic logic [11:0] clamp_phase(input logic signed [13:0] v);
    if (v < 0) begin
      return 12'd0;
    end
    if (v > vfpd_pkg::PHASE_MAX) begin
      return 12'(vfpd_pkg::PHASE_MAX);
    end
    return v[11:0];
  endfunction

  logic signed [13:0] half_s;
  logic signed [13:0] ph_a, ph_b, ph_c;
  logic [11:0]        p5_q [3];
  logic signed [11:0] uq5_q;

  assign half_s = $signed({3'b000, supply_offset_q[11:1]});
  assign ph_a   = 14'(ualpha4_q) + half_s;
  assign ph_b   = 14'(sb4_q) - 14'(halfa4_q) + half_s;
  assign ph_c   = half_s - 14'(halfa4_q) - 14'(sb4_q);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      p5_q[0] <= clamp_phase(ph_a);
      p5_q[1] <= clamp_phase(ph_b);
      p5_q[2] <= clamp_phase(ph_c);
      uq5_q   <= uq4_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: duty numerator and saturation flags
  // ---------------------------------------------------------------------
  logic [NW-1:0]      num_q  [3];
  logic               sat_q  [3];
  logic               zero_q [3];
  logic signed [11:0] uq6_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int l = 0; l < 3; l++) begin
        num_q[l]  <= NW'(p5_q[l]) * NW'(PWM_PERIOD);
        sat_q[l]  <= (full_scale_q == '0)
                   ? (p5_q[l] != '0)
                   : ((LW'(p5_q[l]) * LW'(PWM_PERIOD)) >= fs_limit_q);
        zero_q[l] <= (p5_q[l] == '0);
      end
      uq6_q <= uq5_q;
    end
  end

  // ---------------------------------------------------------------------
  // Divider stages: one quotient bit per stage per phase
  // ---------------------------------------------------------------------
  logic [11:0]        rem_d   [PW][3];
  logic [11:0]        rem_q   [PW][3];
  logic [PW-1:0]      low_d   [PW][3];
  logic [PW-1:0]      low_q   [PW][3];
  logic [PW-1:0]      quo_d   [PW][3];
  logic [PW-1:0]      quo_q   [PW][3];
  logic               dsat_d  [PW][3];
  logic               dsat_q  [PW][3];
  logic               dzero_d [PW][3];
  logic               dzero_q [PW][3];
  logic signed [11:0] duq_d   [PW];
  logic signed [11:0] duq_q   [PW];

  for (genvar k = 0; k < PW; k++) begin : g_div
    if (k == 0) begin : g_first
      assign duq_d[k] = uq6_q;
    end else begin : g_next
      assign duq_d[k] = duq_q[k-1];
    end
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [11:0]   r_in;
      logic [PW-1:0] n_in;
      logic [PW-1:0] q_in;
      logic [12:0]   trial;
      logic          ge;
      if (k == 0) begin : g_src0
        assign r_in            = num_q[l][NW-1:PW];
        assign n_in            = num_q[l][PW-1:0];
        assign q_in            = '0;
        assign dsat_d[k][l]    = sat_q[l];
        assign dzero_d[k][l]   = zero_q[l];
      end else begin : g_srcn
        assign r_in            = rem_q[k-1][l];
        assign n_in            = low_q[k-1][l];
        assign q_in            = quo_q[k-1][l];
        assign dsat_d[k][l]    = dsat_q[k-1][l];
        assign dzero_d[k][l]   = dzero_q[k-1][l];
      end
      assign trial        = {r_in, n_in[PW-1-k]};
      assign ge           = trial >= {1'b0, full_scale_q};
      assign rem_d[k][l]  = ge ? 12'(trial - {1'b0, full_scale_q}) : trial[11:0];
      assign low_d[k][l]  = n_in;
      assign quo_d[k][l]  = {q_in[PW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rem_q   <= rem_d;
      low_q   <= low_d;
      quo_q   <= quo_d;
      dsat_q  <= dsat_d;
      dzero_q <= dzero_d;
      duq_q   <= duq_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result selection
  // ---------------------------------------------------------------------
  logic [PW-1:0] duty_full [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dsat_q[PW-1][l]) begin
        duty_full[l] = PERIOD;
      end else if (dzero_q[PW-1][l]) begin
        duty_full[l] = '0;
      end else begin
        duty_full[l] = quo_q[PW-1][l];
      end
    end
  end

  assign out_valid_o = valid_q[NST-1];
  assign duty_a_o    = 13'(duty_full[0]);
  assign duty_b_o    = 13'(duty_full[1]);
  assign duty_c_o    = 13'(duty_full[2]);
  assign q_voltage_o = duq_q[PW-1];

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `VFPD_ASSERT_NEXT(a_accept_enters, in_accept, valid_q[0])
  `VFPD_ASSERT_NEXT(a_stall_holds, !advance, $stable(valid_q))
  `VFPD_ASSERT_NOW(a_duty_in_range, out_valid_o,
                   (duty_full[0] <= PERIOD) && (duty_full[1] <= PERIOD) &&
                   (duty_full[2] <= PERIOD))
  `VFPD_ASSERT_NOW(a_uq_in_range, out_valid_o,
                   (q_voltage_o <= vfpd_pkg::UQ_LIMIT) &&
                   (q_voltage_o >= -vfpd_pkg::UQ_LIMIT))

endmodule
